// File: rtl/verot_pkg.sv
// ----------------------------------------------------------------------------
// verot_pkg
// Shared constants and elaboration-time trig table builder for the
// ZYX Euler vertex rotation core.
// ----------------------------------------------------------------------------
package verot_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int ANGLE_WIDTH    = 9;
	localparam int ANGLE_COUNT    = 360;
	localparam int ADDR_WIDTH     = 4;
	localparam int DATA_WIDTH     = 32;

	localparam logic [1:0] REG_ANGLE_X = 2'd0;
	localparam logic [1:0] REG_ANGLE_Y = 2'd1;
	localparam logic [1:0] REG_ANGLE_Z = 2'd2;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// sin of r degrees, r in 0..90, Q30, ten-term series
	function automatic logic [63:0] sin_q30_quarter(input logic [6:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = (64'(r) * PI_Q30) / 64'd180;
		x2 = (x * x) >> 30;
		t  = x;
		s  = x;
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd156;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd210;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd272;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd342;
		s  = s - t;
		if (s > ONE_Q30) begin
			s = ONE_Q30;
		end
		return s;
	endfunction

	// sin of deg degrees, deg in 0..359, with frac fraction bits, rounded half up
	function automatic logic signed [63:0] trig_entry(input logic [8:0] deg, input int frac);
		logic [1:0]  q;
		logic [6:0]  r;
		logic [6:0]  arg;
		logic [63:0] s;
		q   = 2'((deg / 9'd90) & 9'd3);
		r   = 7'(deg % 9'd90);
		arg = q[0] ? 7'(7'd90 - r) : r;
		s   = sin_q30_quarter(arg);
		s   = (s + (64'd1 << (29 - frac))) >> (30 - frac);
		return q[1] ? -$signed(s) : $signed(s);
	endfunction

endpackage

// File: rtl/verot_if.sv
// ----------------------------------------------------------------------------
// verot_if
// Valid/ready stream interfaces for vertices in and rotated vertices out.
// ----------------------------------------------------------------------------
interface verot_in_if #(
	parameter int COORD_WIDTH = verot_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] in_x;
	logic signed [COORD_WIDTH-1:0] in_y;
	logic signed [COORD_WIDTH-1:0] in_z;

	modport source (output valid, output in_x, output in_y, output in_z, input ready);
	modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface verot_out_if #(
	parameter int COORD_WIDTH = verot_pkg::COORD_WIDTH
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_WIDTH:0] out_x;
	logic signed [COORD_WIDTH:0] out_y;
	logic signed [COORD_WIDTH:0] out_z;

	modport source (output valid, output out_x, output out_y, output out_z, input ready);
	modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

// File: rtl/vertex_euler_rotation_zyx_core.sv
// ----------------------------------------------------------------------------
// vertex_euler_rotation_zyx_core
// Rotates a signed vertex about z, then y, then x by configured whole-degree
// angles using a per-degree fixed-point sine table.
// ----------------------------------------------------------------------------
//  channel   kind              payload                 width
//  vertex    valid/ready sink  in_x in_y in_z          COORD_WIDTH each, signed
//  result    valid/ready src   out_x out_y out_z       COORD_WIDTH+1 each, signed
//  apb       register port     angle_x/y/z_deg @0,4,8  9 bits each
//
//  One vertex per cycle while no result is held; the three rotation stages
//  are each split into a multiply stage and a sum/scale stage.
//  Reset clears the stage valid bits and sets all angles to zero.
//  A held result freezes every stage; vertex.ready follows that enable.
//  Sine and cosine of each angle are looked up and registered on the write.
// ----------------------------------------------------------------------------
module vertex_euler_rotation_zyx_core #(
	parameter int COORD_WIDTH    = verot_pkg::COORD_WIDTH,
	parameter int TRIG_FRAC_BITS = verot_pkg::TRIG_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	verot_in_if.sink                          vertex,
	verot_out_if.source                       result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [verot_pkg::ADDR_WIDTH-1:0]  paddr,
	input  logic [verot_pkg::DATA_WIDTH-1:0]  pwdata,
	output logic [verot_pkg::DATA_WIDTH-1:0]  prdata,
	output logic                              pready
);

	localparam int W   = COORD_WIDTH;
	localparam int F   = TRIG_FRAC_BITS;
	localparam int TW  = F + 2;
	localparam int AW  = verot_pkg::ANGLE_WIDTH;
	localparam int ACC = W + TW + 4;

	localparam logic signed [ACC-1:0] BIAS    = (ACC'(1) <<< F) - ACC'(1);
	localparam logic signed [ACC-1:0] OUT_MAX = (ACC'(1) <<< W) - ACC'(1);
	localparam logic signed [ACC-1:0] OUT_MIN = -OUT_MAX - ACC'(1);
	localparam logic signed [TW-1:0]  TRIG_ONE = TW'(1) <<< F;

	function automatic logic signed [ACC-1:0] tdiv(input logic signed [ACC-1:0] s);
		return $signed(s + (s[ACC-1] ? BIAS : ACC'(0))) >>> F;
	endfunction

	function automatic logic signed [W:0] sat(input logic signed [ACC-1:0] v);
		logic signed [ACC-1:0] c;
		c = v;
		if (v > OUT_MAX) begin
			c = OUT_MAX;
		end else if (v < OUT_MIN) begin
			c = OUT_MIN;
		end
		return c[W:0];
	endfunction

	// sine table
	logic signed [TW-1:0] sin_rom [verot_pkg::ANGLE_COUNT];

	for (genvar d = 0; d < verot_pkg::ANGLE_COUNT; d++) begin : g_rom
		assign sin_rom[d] = TW'(verot_pkg::trig_entry(9'(d), F));
	end

	// configuration
	logic [AW-1:0]        ang_x_q, ang_y_q, ang_z_q;
	logic signed [TW-1:0] sin_x_q, sin_y_q, sin_z_q;
	logic signed [TW-1:0] cos_x_q, cos_y_q, cos_z_q;
	logic [AW-1:0]        wr_raw, wr_ang, wr_cos_idx;
	logic                 wr_en;
	logic [1:0]           reg_idx;

	assign pready     = 1'b1;
	assign reg_idx    = paddr[verot_pkg::ADDR_WIDTH-1:2];
	assign wr_en      = psel && penable && pwrite && pready;
	assign wr_raw     = pwdata[AW-1:0];
	assign wr_ang     = (wr_raw >= AW'(360)) ? AW'(wr_raw - AW'(360)) : wr_raw;
	assign wr_cos_idx = (wr_ang >= AW'(270)) ? AW'(wr_ang - AW'(270)) : AW'(wr_ang + AW'(90));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_x_q <= '0;
			ang_y_q <= '0;
			ang_z_q <= '0;
			sin_x_q <= '0;
			sin_y_q <= '0;
			sin_z_q <= '0;
			cos_x_q <= TRIG_ONE;
			cos_y_q <= TRIG_ONE;
			cos_z_q <= TRIG_ONE;
		end else if (wr_en) begin
			unique case (reg_idx)
				verot_pkg::REG_ANGLE_X: begin
					ang_x_q <= wr_raw;
					sin_x_q <= sin_rom[wr_ang];
					cos_x_q <= sin_rom[wr_cos_idx];
				end
				verot_pkg::REG_ANGLE_Y: begin
					ang_y_q <= wr_raw;
					sin_y_q <= sin_rom[wr_ang];
					cos_y_q <= sin_rom[wr_cos_idx];
				end
				verot_pkg::REG_ANGLE_Z: begin
					ang_z_q <= wr_raw;
					sin_z_q <= sin_rom[wr_ang];
					cos_z_q <= sin_rom[wr_cos_idx];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			verot_pkg::REG_ANGLE_X: prdata = verot_pkg::DATA_WIDTH'(ang_x_q);
			verot_pkg::REG_ANGLE_Y: prdata = verot_pkg::DATA_WIDTH'(ang_y_q);
			verot_pkg::REG_ANGLE_Z: prdata = verot_pkg::DATA_WIDTH'(ang_z_q);
			default:                prdata = '0;
		endcase
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;

	assign adv          = !v_s6 || result.ready;
	assign vertex.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vertex.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// datapath
	logic signed [W+TW-1:0] xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [W-1:0]    z_s1;
	logic signed [W:0]      x_s2, y_s2;
	logic signed [W-1:0]    z_s2;
	logic signed [W+TW:0]   xc_s3, zs_s3, xs_s3, zc_s3;
	logic signed [W:0]      y_s3;
	logic signed [W+1:0]    x_s4, z_s4;
	logic signed [W:0]      y_s4;
	logic signed [W+TW+1:0] yc_s5, zs_s5, ys_s5, zc_s5;
	logic signed [W+1:0]    x_s5;
	logic signed [W:0]      x_s6, y_s6, z_s6;

	logic signed [ACC-1:0]  za_sum, zb_sum, ya_sum, yb_sum, xa_sum, xb_sum;
	logic signed [ACC-1:0]  za_q, zb_q, ya_q, yb_q, xa_q, xb_q;

	always_comb begin
		za_sum = ACC'(xc_s1) - ACC'(ys_s1);
		zb_sum = ACC'(xs_s1) + ACC'(yc_s1);
		ya_sum = ACC'(xc_s3) - ACC'(zs_s3);
		yb_sum = ACC'(xs_s3) + ACC'(zc_s3);
		xa_sum = ACC'(yc_s5) - ACC'(zs_s5);
		xb_sum = ACC'(ys_s5) + ACC'(zc_s5);
		za_q   = tdiv(za_sum);
		zb_q   = tdiv(zb_sum);
		ya_q   = tdiv(ya_sum);
		yb_q   = tdiv(yb_sum);
		xa_q   = tdiv(xa_sum);
		xb_q   = tdiv(xb_sum);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xc_s1 <= vertex.in_x * cos_z_q;
			ys_s1 <= vertex.in_y * sin_z_q;
			xs_s1 <= vertex.in_x * sin_z_q;
			yc_s1 <= vertex.in_y * cos_z_q;
			z_s1  <= vertex.in_z;

			x_s2  <= za_q[W:0];
			y_s2  <= zb_q[W:0];
			z_s2  <= z_s1;

			xc_s3 <= x_s2 * cos_y_q;
			zs_s3 <= (W+1)'(z_s2) * sin_y_q;
			xs_s3 <= x_s2 * sin_y_q;
			zc_s3 <= (W+1)'(z_s2) * cos_y_q;
			y_s3  <= y_s2;

			x_s4  <= ya_q[W+1:0];
			z_s4  <= yb_q[W+1:0];
			y_s4  <= y_s3;

			yc_s5 <= (W+2)'(y_s4) * cos_x_q;
			zs_s5 <= z_s4 * sin_x_q;
			ys_s5 <= (W+2)'(y_s4) * sin_x_q;
			zc_s5 <= z_s4 * cos_x_q;
			x_s5  <= x_s4;

			x_s6  <= sat(ACC'(x_s5));
			y_s6  <= sat(xa_q);
			z_s6  <= sat(xb_q);
		end
	end

	assign result.valid = v_s6;
	assign result.out_x = x_s6;
	assign result.out_y = y_s6;
	assign result.out_z = z_s6;

endmodule

// File: rtl/verot_checker.sv
// ----------------------------------------------------------------------------
// verot_checker
// Port-level checks for the ZYX Euler vertex rotation core, bound to the top.
// ----------------------------------------------------------------------------
module verot_checker #(
	parameter int OUT_WIDTH = verot_pkg::COORD_WIDTH + 1
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 vin_ready,
	input logic                 vout_valid,
	input logic                 vout_ready,
	input logic [OUT_WIDTH-1:0] out_x,
	input logic [OUT_WIDTH-1:0] out_y,
	input logic [OUT_WIDTH-1:0] out_z,
	input logic                 pready
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		vout_valid && !vout_ready |=> vout_valid)
		else $error("result dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		vout_valid && !vout_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("result payload changed while stalled");

	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(vout_ready || !vout_valid) |-> vin_ready)
		else $error("vertex refused while the result side can advance");

	a_pready: assert property (@(posedge clk) pready)
		else $error("register port wait state");

endmodule

bind vertex_euler_rotation_zyx_core verot_checker #(
	.OUT_WIDTH(COORD_WIDTH + 1)
) u_verot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vin_ready (vertex.ready),
	.vout_valid(result.valid),
	.vout_ready(result.ready),
	.out_x     (result.out_x),
	.out_y     (result.out_y),
	.out_z     (result.out_z),
	.pready    (pready)
);

// File: test/verot_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verot_rotation_checker
// Watches the vertex, result and register channels of the rotation core.
// Keeps its own angle copies from the register writes and its own sine table,
// predicts every rotated vertex in order and compares it field by field.
// ----------------------------------------------------------------------------
module verot_rotation_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	verot_in_if                              vertex,
	verot_out_if                             result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [verot_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [verot_pkg::DATA_WIDTH-1:0] pwdata,
	input  logic [verot_pkg::DATA_WIDTH-1:0] prdata,
	input  logic                             pready,
	output int                               mismatches,
	output int                               outstanding
);

	localparam int          OUT_WIDTH = verot_pkg::COORD_WIDTH + 1;
	localparam int          FRAC      = verot_pkg::TRIG_FRAC_BITS;
	localparam int          AWIDTH    = verot_pkg::ANGLE_WIDTH;
	localparam int          ACOUNT    = verot_pkg::ANGLE_COUNT;
	localparam logic [63:0] PI_FIXED  = 64'd3373259426;
	localparam logic [63:0] UNIT_Q30  = 64'd1 << 30;

	typedef logic signed [OUT_WIDTH-1:0] coord_out_t;
	typedef struct packed {
		coord_out_t x;
		coord_out_t y;
		coord_out_t z;
	} rotated_vertex_t;

	longint            sine_table [ACOUNT];
	logic [AWIDTH-1:0] angle_x = '0;
	logic [AWIDTH-1:0] angle_y = '0;
	logic [AWIDTH-1:0] angle_z = '0;
	logic [AWIDTH-1:0] readback;
	rotated_vertex_t   expected_vertices [$];
	rotated_vertex_t   want;
	rotated_vertex_t   got;
	coord_out_t        want_field [3];
	coord_out_t        got_field [3];
	string             field_name [3] = '{"out_x", "out_y", "out_z"};

	// sine of 0..90 degrees in Q30 from a ten-term series
	function automatic logic [63:0] quarter_sine_q30(input int deg);
		logic [63:0] arg;
		logic [63:0] arg_sq;
		logic [63:0] term;
		logic [63:0] acc;
		arg    = (64'(deg) * PI_FIXED) / 64'd180;
		arg_sq = (arg * arg) >> 30;
		term   = arg;
		acc    = arg;
		for (int k = 1; k <= 9; k++) begin
			term = ((term * arg_sq) >> 30) / 64'(2 * k * (2 * k + 1));
			acc  = (k % 2 == 1) ? acc - term : acc + term;
		end
		return (acc > UNIT_Q30) ? UNIT_Q30 : acc;
	endfunction

	function automatic longint degree_sine(input int deg);
		int          quadrant;
		int          folded;
		logic [63:0] mag;
		quadrant = deg / 90;
		folded   = (quadrant % 2 == 1) ? 90 - deg % 90 : deg % 90;
		mag      = (quarter_sine_q30(folded) + (64'd1 << (29 - FRAC)))
			>> (30 - FRAC);
		return (quadrant >= 2) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic int wrapped(input logic [AWIDTH-1:0] angle);
		return (angle >= ACOUNT) ? int'(angle) - ACOUNT : int'(angle);
	endfunction

	function automatic longint turned_first(input longint a, input longint b, input int deg);
		return (a * sine_table[(deg + 90) % ACOUNT] - b * sine_table[deg])
			/ (longint'(1) << FRAC);
	endfunction

	function automatic longint turned_second(input longint a, input longint b, input int deg);
		return (a * sine_table[deg] + b * sine_table[(deg + 90) % ACOUNT])
			/ (longint'(1) << FRAC);
	endfunction

	function automatic coord_out_t saturated(input longint v);
		longint hi;
		hi = (longint'(1) << (OUT_WIDTH - 1)) - 1;
		if (v > hi) return coord_out_t'(hi);
		if (v < -hi - 1) return coord_out_t'(-hi - 1);
		return coord_out_t'(v);
	endfunction

	function automatic rotated_vertex_t predict_rotation(
		input logic signed [verot_pkg::COORD_WIDTH-1:0] in_x,
		input logic signed [verot_pkg::COORD_WIDTH-1:0] in_y,
		input logic signed [verot_pkg::COORD_WIDTH-1:0] in_z
	);
		longint          x;
		longint          y;
		longint          z;
		longint          t;
		int              deg;
		rotated_vertex_t r;
		x   = in_x;
		y   = in_y;
		z   = in_z;
		deg = wrapped(angle_z);
		t   = turned_first(x, y, deg);
		y   = turned_second(x, y, deg);
		x   = t;
		deg = wrapped(angle_y);
		t   = turned_first(x, z, deg);
		z   = turned_second(x, z, deg);
		x   = t;
		deg = wrapped(angle_x);
		t   = turned_first(y, z, deg);
		z   = turned_second(y, z, deg);
		y   = t;
		r.x = saturated(x);
		r.y = saturated(y);
		r.z = saturated(z);
		return r;
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		for (int d = 0; d < ACOUNT; d++) begin
			sine_table[d] = degree_sine(d);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pready) begin
				case (paddr[verot_pkg::ADDR_WIDTH-1:2])
					verot_pkg::REG_ANGLE_X: readback = angle_x;
					verot_pkg::REG_ANGLE_Y: readback = angle_y;
					default:                readback = angle_z;
				endcase
				if (pwrite) begin
					case (paddr[verot_pkg::ADDR_WIDTH-1:2])
						verot_pkg::REG_ANGLE_X: angle_x = pwdata[AWIDTH-1:0];
						verot_pkg::REG_ANGLE_Y: angle_y = pwdata[AWIDTH-1:0];
						verot_pkg::REG_ANGLE_Z: angle_z = pwdata[AWIDTH-1:0];
						default: ;
					endcase
				end else if (prdata !== verot_pkg::DATA_WIDTH'(readback)) begin
					$display("%0t: register 0x%0h expected %0d got %0d",
						$time, paddr, readback, prdata);
					mismatches++;
				end
			end
			if (vertex.valid && vertex.ready) begin
				expected_vertices.push_back(
					predict_rotation(vertex.in_x, vertex.in_y, vertex.in_z));
			end
			if (result.valid && result.ready) begin
				if (expected_vertices.size() == 0) begin
					$display("%0t: rotated vertex expected none got %0d %0d %0d",
						$time, result.out_x, result.out_y, result.out_z);
					mismatches++;
				end else begin
					want       = expected_vertices.pop_front();
					got        = '{result.out_x, result.out_y, result.out_z};
					want_field = '{want.x, want.y, want.z};
					got_field  = '{got.x, got.y, got.z};
					for (int i = 0; i < 3; i++) begin
						if (got_field[i] !== want_field[i]) begin
							$display("%0t: %s expected %0d got %0d",
								$time, field_name[i], want_field[i], got_field[i]);
							mismatches++;
						end
					end
				end
			end
			outstanding <= expected_vertices.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ZYX Euler rotation core: directed corner
// vertices under reset, wrapped and quarter-turn angles, then random vertices
// under twelve angle settings with shifting idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CW                = verot_pkg::COORD_WIDTH;
	localparam int AWIDTH            = verot_pkg::ANGLE_WIDTH;
	localparam int ACOUNT            = verot_pkg::ANGLE_COUNT;
	localparam int QUIET_LIMIT       = 4000;
	localparam int SETTING_COUNT     = 12;
	localparam int ITEMS_PER_SETTING = 125;
	localparam int COORD_MAX         = 2 ** (CW - 1) - 1;

	logic                             clk;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [verot_pkg::ADDR_WIDTH-1:0] paddr;
	logic [verot_pkg::DATA_WIDTH-1:0] pwdata;
	logic [verot_pkg::DATA_WIDTH-1:0] prdata;
	logic                             pready;
	int                               mismatches;
	int                               outstanding;
	int                               quiet_cycles = 0;
	int                               gap_pct      = 18;
	int                               stall_pct    = 68;

	int directed_xyz [8][3] = '{
		'{0, 0, 0},
		'{32767, 32767, 32767},
		'{-32768, -32768, -32768},
		'{32767, -32768, 32767},
		'{-32768, 32767, -32768},
		'{1, -1, 1},
		'{-1, -2, -3},
		'{12345, -23456, 777}
	};
	int directed_angles [3][3] = '{
		'{0, 0, 0},
		'{359, 511, 360},
		'{90, 180, 270}
	};

	verot_in_if  vertex_ch ();
	verot_out_if result_ch ();

	vertex_euler_rotation_zyx_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vertex  (vertex_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	verot_rotation_checker rotation_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex      (vertex_ch),
		.result      (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((vertex_ch.valid && vertex_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [CW-1:0] random_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) return CW'($urandom);
		if (pick < 8) return CW'(int'($urandom_range(0, 256)) - 128);
		if (pick == 8) begin
			return $urandom_range(0, 1) ? CW'(COORD_MAX - int'($urandom_range(0, 3)))
				: CW'(-COORD_MAX - 1 + int'($urandom_range(0, 3)));
		end
		return CW'(int'($urandom_range(0, 2)) - 1);
	endfunction

	function automatic logic [AWIDTH-1:0] random_angle();
		return ($urandom_range(0, 3) == 0) ? AWIDTH'($urandom_range(ACOUNT, 511))
			: AWIDTH'($urandom_range(0, ACOUNT - 1));
	endfunction

	task automatic apb_access(input logic write_en, input logic [1:0] reg_index,
		input logic [AWIDTH-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write_en;
		paddr   <= verot_pkg::ADDR_WIDTH'({reg_index, 2'b00});
		pwdata  <= verot_pkg::DATA_WIDTH'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_angles(input logic [AWIDTH-1:0] ax, input logic [AWIDTH-1:0] ay,
		input logic [AWIDTH-1:0] az);
		apb_access(1'b1, verot_pkg::REG_ANGLE_X, ax);
		apb_access(1'b1, verot_pkg::REG_ANGLE_Y, ay);
		apb_access(1'b1, verot_pkg::REG_ANGLE_Z, az);
		apb_access(1'b0, verot_pkg::REG_ANGLE_X, '0);
		apb_access(1'b0, verot_pkg::REG_ANGLE_Y, '0);
		apb_access(1'b0, verot_pkg::REG_ANGLE_Z, '0);
	endtask

	task automatic send_vertex(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
		while ($urandom_range(0, 99) < gap_pct) begin
			vertex_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vertex_ch.valid <= 1'b1;
		vertex_ch.in_x  <= x;
		vertex_ch.in_y  <= y;
		vertex_ch.in_z  <= z;
		do @(posedge clk); while (!vertex_ch.ready);
	endtask

	// drop valid and hold until every transaction has come back
	task automatic settle();
		vertex_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		logic [AWIDTH-1:0] ax;
		logic [AWIDTH-1:0] ay;
		logic [AWIDTH-1:0] az;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		vertex_ch.valid <= 1'b0;
		vertex_ch.in_x  <= '0;
		vertex_ch.in_y  <= '0;
		vertex_ch.in_z  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int c = 0; c < 3; c++) begin
			if (c > 0) begin
				set_angles(AWIDTH'(directed_angles[c][0]), AWIDTH'(directed_angles[c][1]),
					AWIDTH'(directed_angles[c][2]));
			end
			for (int v = 0; v < 8; v++) begin
				send_vertex(CW'(directed_xyz[v][0]), CW'(directed_xyz[v][1]),
					CW'(directed_xyz[v][2]));
			end
			settle();
		end

		for (int s = 0; s < SETTING_COUNT; s++) begin
			if (s == 4) begin
				gap_pct   = 68;
				stall_pct = 18;
			end
			if (s == 8) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			case (s)
				0: begin ax = 0; ay = 0; az = 0; end
				1: begin ax = 359; ay = 359; az = 359; end
				2: begin ax = 511; ay = 511; az = 511; end
				3: begin ax = 360; ay = 0; az = 359; end
				default: begin
					ax = random_angle();
					ay = random_angle();
					az = random_angle();
				end
			endcase
			set_angles(ax, ay, az);
			repeat (ITEMS_PER_SETTING) send_vertex(random_coord(), random_coord(), random_coord());
			settle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/verot_pkg.sv
rtl/verot_if.sv
rtl/vertex_euler_rotation_zyx_core.sv
rtl/verot_checker.sv
test/verot_rotation_checker.sv
test/tb_top.sv
